@@ rtl/bth_pkg.sv @@
// ----------------------------------------------------------------------------
// bth_pkg
// Shared constants, codes and types of the binary transition histogram.
// ----------------------------------------------------------------------------
package bth_pkg;

    localparam int MAX_CELLS_DEF   = 64;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int BIN_COUNT       = 9;
    localparam int QUEUE_DEPTH     = 2;

    localparam int HALF_W   = 6;
    localparam int ONES_W   = 7;
    localparam int CELL_W   = 2;
    localparam int POS_W    = 6;
    localparam int SEL_W    = 4;
    localparam int OUT_W    = 32;

    localparam logic [HALF_W-1:0] HALF_RESET = 6'd32;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam int BIN_PAIR   = 0;
    localparam int BIN_FIRST  = 1;
    localparam int BIN_SECOND = 5;

    typedef struct packed {
        logic                 is_read;
        logic                 read_ok;
        logic [SEL_W-1:0]     sel;
        logic [BIN_COUNT-1:0] bump;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    typedef enum logic [1:0] {
        BACK_CLEAR,
        BACK_IDLE,
        BACK_APPLY
    } back_state_t;

    typedef struct packed {
        logic clearing;
        logic applying;
    } back_status_t;

endpackage

@@ rtl/binary_transition_histogram.sv @@
// ----------------------------------------------------------------------------
// binary_transition_histogram
// Histogram of cell transitions between two binary configurations.
// ----------------------------------------------------------------------------
// After reset the block clears all (MAX_CELLS+1)^2 rows of its counter memory
// (4225 at the default), one row of nine counters a cycle, with busy high;
// half length writes are taken during that time. A command beat is taken
// when start is high and busy is low. In the back end every beat first has
// its counter row read, then the row written back or a counter returned; the
// back end takes no new beat until it is through with the last, and the
// two-entry queue lets start bursts run ahead until it fills. A read beat
// gives its count_value with done high for one cycle, in the back end's
// apply state, once the beats queued or in the back end ahead of it are
// through. done cannot be held off, so capture it when it appears.
// ----------------------------------------------------------------------------
module binary_transition_histogram #(
    parameter int MAX_CELLS   = bth_pkg::MAX_CELLS_DEF,
    parameter int COUNT_WIDTH = bth_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bth_pkg::HALF_W-1:0]  cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic                        operation,
    input  logic [bth_pkg::ONES_W-1:0]  ones_before,
    input  logic [bth_pkg::ONES_W-1:0]  ones_after,
    input  logic [bth_pkg::CELL_W-1:0]  cell_before,
    input  logic [bth_pkg::CELL_W-1:0]  cell_after,
    input  logic [bth_pkg::POS_W-1:0]   cell_position,
    input  logic [bth_pkg::SEL_W-1:0]   bin_select,
    output logic                        done,
    output logic [bth_pkg::OUT_W-1:0]   count_value
);

    localparam int RowCount = MAX_CELLS + 1;
    localparam int AddrW    = $clog2(RowCount * RowCount);
    localparam int EntryW   = bth_pkg::ITEM_W + AddrW;

    logic                  push;
    bth_pkg::item_t        push_item;
    logic [AddrW-1:0]      push_addr;
    logic                  pop;
    logic                  q_valid;
    logic [EntryW-1:0]     q_data;
    logic                  q_full;
    bth_pkg::item_t        q_item;
    logic [AddrW-1:0]      q_addr;
    bth_pkg::back_status_t back_status;

    assign busy   = back_status.clearing || q_full;
    assign q_item = bth_pkg::item_t'(q_data[EntryW-1:AddrW]);
    assign q_addr = q_data[AddrW-1:0];

    bth_front #(
        .MAX_CELLS (MAX_CELLS),
        .ADDR_W    (AddrW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .ones_before   (ones_before),
        .ones_after    (ones_after),
        .cell_before   (cell_before),
        .cell_after    (cell_after),
        .cell_position (cell_position),
        .bin_select    (bin_select),
        .push          (push),
        .push_item     (push_item),
        .push_addr     (push_addr)
    );

    bth_queue #(
        .DATA_W (EntryW),
        .DEPTH  (bth_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_item, push_addr}),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .full      (q_full)
    );

    bth_back #(
        .MAX_CELLS   (MAX_CELLS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ADDR_W      (AddrW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_addr      (q_addr),
        .pop         (pop),
        .status      (back_status),
        .done        (done),
        .count_value (count_value)
    );

endmodule

@@ rtl/bth_front.sv @@
// ----------------------------------------------------------------------------
// bth_front
// Accepts command beats, holds the half length register and classifies each
// beat into a row address and a set of bins to bump or a bin to read.
// ----------------------------------------------------------------------------
module bth_front #(
    parameter int MAX_CELLS = bth_pkg::MAX_CELLS_DEF,
    parameter int ADDR_W    = 13
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bth_pkg::HALF_W-1:0]  cfg_data,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        operation,
    input  logic [bth_pkg::ONES_W-1:0]  ones_before,
    input  logic [bth_pkg::ONES_W-1:0]  ones_after,
    input  logic [bth_pkg::CELL_W-1:0]  cell_before,
    input  logic [bth_pkg::CELL_W-1:0]  cell_after,
    input  logic [bth_pkg::POS_W-1:0]   cell_position,
    input  logic [bth_pkg::SEL_W-1:0]   bin_select,
    output logic                        push,
    output bth_pkg::item_t              push_item,
    output logic [ADDR_W-1:0]           push_addr
);

    localparam int RowCount = MAX_CELLS + 1;

    logic [bth_pkg::HALF_W-1:0] half_length_reg;
    logic [bth_pkg::HALF_W-1:0] half_length_next;
    logic                       in_table;
    logic                       cells_binary;
    logic [1:0]                 kind;
    logic                       in_first;
    logic                       in_second;

    always_comb
    begin
        half_length_next = cfg_we ? cfg_data : half_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= bth_pkg::HALF_RESET;
        end
        else
        begin
            half_length_reg <= half_length_next;
        end
    end

    always_comb
    begin
        in_table     = (32'(ones_before) < 32'(RowCount)) && (32'(ones_after) < 32'(RowCount));
        cells_binary = !cell_before[1] && !cell_after[1];
        kind         = {cell_before[0], cell_after[0]};
        in_first     = cell_position < half_length_reg;
        in_second    = !in_first && ({1'b0, cell_position} < {half_length_reg, 1'b0});

        push_addr = ADDR_W'(ones_before) * ADDR_W'(RowCount) + ADDR_W'(ones_after);

        push_item.is_read = (operation == bth_pkg::OP_READ);
        push_item.read_ok = in_table && (32'(bin_select) < 32'(bth_pkg::BIN_COUNT));
        push_item.sel     = push_item.read_ok ? bin_select : '0;
        push_item.bump    = '0;
        if (!push_item.is_read)
        begin
            push_item.bump[bth_pkg::BIN_PAIR] = (cell_position == '0);
            for (int k = 0; k < 4; k++)
            begin
                if (cells_binary && (32'(kind) == k))
                begin
                    push_item.bump[bth_pkg::BIN_FIRST + k]  = in_first;
                    push_item.bump[bth_pkg::BIN_SECOND + k] = in_second;
                end
            end
        end

        // drop record beats that fall outside the table
        push = start && !busy && (push_item.is_read || in_table);
    end

endmodule

@@ rtl/bth_queue.sv @@
// ----------------------------------------------------------------------------
// bth_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bth_queue #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = bth_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data,
    output logic              full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;

    function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] ptr);
        logic [PtrW-1:0] res;
        res = (32'(ptr) == DEPTH - 1) ? '0 : ptr + 1'b1;
        return res;
    endfunction

    always_comb
    begin
        full        = (32'(count_reg) == DEPTH);
        pop_valid   = (count_reg != '0);
        pop_data    = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? advance(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? advance(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue pop while empty");

endmodule

@@ rtl/bth_back.sv @@
// ----------------------------------------------------------------------------
// bth_back
// Clears the counter memory after reset, then carries out queued beats as a
// row read followed by a saturating write-back or a counter read-out.
// ----------------------------------------------------------------------------
module bth_back #(
    parameter int MAX_CELLS   = bth_pkg::MAX_CELLS_DEF,
    parameter int COUNT_WIDTH = bth_pkg::COUNT_WIDTH_DEF,
    parameter int ADDR_W      = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  bth_pkg::item_t             q_item,
    input  logic [ADDR_W-1:0]          q_addr,
    output logic                       pop,
    output bth_pkg::back_status_t      status,
    output logic                       done,
    output logic [bth_pkg::OUT_W-1:0]  count_value
);

    localparam int RowCount = MAX_CELLS + 1;
    localparam int Rows     = RowCount * RowCount;

    bth_pkg::back_state_t state_reg;
    bth_pkg::back_state_t state_next;
    logic [ADDR_W-1:0]    clear_addr_reg;
    logic [ADDR_W-1:0]    clear_addr_next;
    bth_pkg::item_t       cur_item_reg;
    logic [ADDR_W-1:0]    cur_addr_reg;

    logic [bth_pkg::BIN_COUNT-1:0][COUNT_WIDTH-1:0] mem [Rows];
    logic [bth_pkg::BIN_COUNT-1:0][COUNT_WIDTH-1:0] rd_data_reg;
    logic [bth_pkg::BIN_COUNT-1:0][COUNT_WIDTH-1:0] new_row;
    logic [bth_pkg::BIN_COUNT-1:0][COUNT_WIDTH-1:0] mem_wdata;
    logic                                           mem_we;
    logic [ADDR_W-1:0]                              mem_waddr;
    logic [COUNT_WIDTH-1:0]                         sel_count;
    logic                                           last_row;

    assign last_row = (32'(clear_addr_reg) == Rows - 1);

    // next state
    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        case (state_reg)
            bth_pkg::BACK_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (last_row)
                begin
                    state_next = bth_pkg::BACK_IDLE;
                end
            end
            bth_pkg::BACK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = bth_pkg::BACK_APPLY;
                end
            end
            bth_pkg::BACK_APPLY:
            begin
                state_next = bth_pkg::BACK_IDLE;
            end
            default:
            begin
                state_next = bth_pkg::BACK_IDLE;
            end
        endcase
    end

    // bump selected bins, hold saturated ones
    always_comb
    begin
        for (int b = 0; b < bth_pkg::BIN_COUNT; b++)
        begin
            if (cur_item_reg.bump[b] && (rd_data_reg[b] != '1))
            begin
                new_row[b] = rd_data_reg[b] + 1'b1;
            end
            else
            begin
                new_row[b] = rd_data_reg[b];
            end
        end
        sel_count = cur_item_reg.read_ok ? rd_data_reg[cur_item_reg.sel] : '0;
    end

    // outputs
    always_comb
    begin
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = cur_addr_reg;
        mem_wdata       = new_row;
        done            = 1'b0;
        status.clearing = 1'b0;
        status.applying = 1'b0;
        case (state_reg)
            bth_pkg::BACK_CLEAR:
            begin
                status.clearing = 1'b1;
                mem_we          = 1'b1;
                mem_waddr       = clear_addr_reg;
                mem_wdata       = '0;
            end
            bth_pkg::BACK_IDLE:
            begin
                pop = q_valid;
            end
            bth_pkg::BACK_APPLY:
            begin
                status.applying = 1'b1;
                mem_we          = !cur_item_reg.is_read;
                done            = cur_item_reg.is_read;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        count_value = bth_pkg::OUT_W'(sel_count);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_data_reg <= mem[q_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_item_reg <= q_item;
            cur_addr_reg <= q_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bth_pkg::BACK_CLEAR;
            clear_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    a_pop_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == bth_pkg::BACK_APPLY))
        else $error("pop not followed by apply");

    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result beats");

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> (!pop && !done))
        else $error("activity during clearing pass");

endmodule

@@ dv/tb_binary_transition_histogram.sv @@
// ----------------------------------------------------------------------------
// tb_binary_transition_histogram
// Self-checking bench for the binary transition histogram. Command beats go
// in through start/busy with random idle gaps. The bench tracks the counter
// table (pair bin, first and second group bins, saturation, cells outside
// the table) itself and checks every count_value that done marks, in order.
// Directed beats cover cleared counters, both groups, ignored cell values,
// out-of-range rows, columns and bins, and the extreme half lengths. They
// are followed by random configuration pairs with read-back, plus noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_binary_transition_histogram;

    import bth_pkg::*;

    localparam int                CLK_HALF     = 6;
    localparam int                ROWS         = MAX_CELLS_DEF + 1;
    localparam int                DRAIN_CYCLES = 8;
    localparam int                PHASE_BEATS  = 230;
    localparam logic [OUT_W-1:0]  COUNT_MAX    = '1;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [HALF_W-1:0]   cfg_data      = '0;
    logic                start         = 1'b0;
    logic                operation     = OP_RECORD;
    logic [ONES_W-1:0]   ones_before   = '0;
    logic [ONES_W-1:0]   ones_after    = '0;
    logic [CELL_W-1:0]   cell_before   = '0;
    logic [CELL_W-1:0]   cell_after    = '0;
    logic [POS_W-1:0]    cell_position = '0;
    logic [SEL_W-1:0]    bin_select    = '0;
    logic                busy;
    logic                done;
    logic [OUT_W-1:0]    count_value;

    logic [OUT_W-1:0]    model_counts [int];
    logic [HALF_W-1:0]   model_half = HALF_RESET;
    logic [OUT_W-1:0]    pending_counts [$];
    int                  mismatches = 0;
    int                  beats_sent = 0;
    bit                  steady     = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    binary_transition_histogram uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .ones_before   (ones_before),
        .ones_after    (ones_after),
        .cell_before   (cell_before),
        .cell_after    (cell_after),
        .cell_position (cell_position),
        .bin_select    (bin_select),
        .done          (done),
        .count_value   (count_value)
    );

    function automatic int count_key(int row, int col, int bin);
        return (row * ROWS + col) * BIN_COUNT + bin;
    endfunction

    function automatic logic [OUT_W-1:0] stored_count(int key);
        return model_counts.exists(key) ? model_counts[key] : '0;
    endfunction

    function automatic void bump_count(int key);
        if (stored_count(key) != COUNT_MAX)
            model_counts[key] = stored_count(key) + 1'b1;
    endfunction

    function automatic void tally_beat(logic op, int row, int col, int cb, int ca,
                                       int pos, int sel);
        bit in_range;
        int kind;
        in_range = (row < ROWS) && (col < ROWS);
        if (op == OP_READ)
        begin
            if (in_range && sel < BIN_COUNT)
                pending_counts.push_back(stored_count(count_key(row, col, sel)));
            else
                pending_counts.push_back('0);
            return;
        end
        if (!in_range)
            return;
        if (pos == 0)
            bump_count(count_key(row, col, BIN_PAIR));
        if (cb <= 1 && ca <= 1)
        begin
            kind = cb * 2 + ca;
            if (pos < int'(model_half))
                bump_count(count_key(row, col, BIN_FIRST + kind));
            else if (pos < 2 * int'(model_half))
                bump_count(count_key(row, col, BIN_SECOND + kind));
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic void note_mismatch(string what, logic [OUT_W-1:0] want,
                                          logic [OUT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s count_value expected %0d got %0d", $time, what, want, got);
    endfunction

    task automatic issue_beat(logic op, logic [ONES_W-1:0] row, logic [ONES_W-1:0] col,
                              logic [CELL_W-1:0] cb, logic [CELL_W-1:0] ca,
                              logic [POS_W-1:0] pos, logic [SEL_W-1:0] sel);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        operation     <= op;
        ones_before   <= row;
        ones_after    <= col;
        cell_before   <= cb;
        cell_after    <= ca;
        cell_position <= pos;
        bin_select    <= sel;
        do
            @(posedge clk);
        while (busy);
        tally_beat(op, int'(row), int'(col), int'(cb), int'(ca), int'(pos), int'(sel));
        beats_sent++;
    endtask

    task automatic record_cell(logic [ONES_W-1:0] row, logic [ONES_W-1:0] col,
                               logic [CELL_W-1:0] cb, logic [CELL_W-1:0] ca,
                               logic [POS_W-1:0] pos);
        issue_beat(OP_RECORD, row, col, cb, ca, pos, SEL_W'($urandom));
    endtask

    task automatic read_counter(logic [ONES_W-1:0] row, logic [ONES_W-1:0] col,
                                logic [SEL_W-1:0] sel);
        issue_beat(OP_READ, row, col, CELL_W'($urandom), CELL_W'($urandom),
                   POS_W'($urandom), sel);
    endtask

    task automatic set_half_length(logic [HALF_W-1:0] value);
        start <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        model_half = value;
    endtask

    task automatic test_cleared_store();
        read_counter(0, 0, SEL_W'(BIN_PAIR));
        read_counter(ONES_W'(MAX_CELLS_DEF), ONES_W'(MAX_CELLS_DEF), SEL_W'(BIN_COUNT - 1));
    endtask

    task automatic test_groups_and_pairs();
        record_cell(3, 5, 0, 1, 0);
        record_cell(3, 5, 1, 1, 40);
        record_cell(3, 5, 1, 0, 63);
        read_counter(3, 5, SEL_W'(BIN_PAIR));
        read_counter(3, 5, SEL_W'(BIN_FIRST + 1));
        read_counter(3, 5, SEL_W'(BIN_SECOND + 3));
        read_counter(3, 5, SEL_W'(BIN_SECOND + 2));
    endtask

    task automatic test_ignored_cells();
        record_cell(3, 5, 2, 1, 1);
        record_cell(3, 5, 3, 3, 0);
        read_counter(3, 5, SEL_W'(BIN_PAIR));
    endtask

    task automatic test_outside_table();
        record_cell(ONES_W'(ROWS), 0, 0, 0, 0);
        read_counter(ONES_W'(ROWS), 0, SEL_W'(BIN_PAIR));
        read_counter('1, '1, SEL_W'(BIN_PAIR));
        read_counter(3, 5, SEL_W'(BIN_COUNT));
        read_counter(3, 5, '1);
    endtask

    task automatic test_half_extremes();
        logic [ONES_W-1:0] top;
        top = ONES_W'(MAX_CELLS_DEF);
        set_half_length(0);
        record_cell(top, top, 0, 0, 0);
        read_counter(top, top, SEL_W'(BIN_PAIR));
        read_counter(top, top, SEL_W'(BIN_FIRST));
        set_half_length('1);
        record_cell(top, top, 1, 1, 63);
        read_counter(top, top, SEL_W'(BIN_SECOND + 3));
        set_half_length(1);
        record_cell(top, top, 0, 0, 1);
        record_cell(top, top, 0, 0, 2);
        read_counter(top, top, SEL_W'(BIN_SECOND));
    endtask

    task automatic send_config_pair();
        logic [ONES_W-1:0] row;
        logic [ONES_W-1:0] col;
        logic [CELL_W-1:0] cb;
        logic [CELL_W-1:0] ca;
        int                limit;
        int                span;
        steady = ($urandom_range(0, 99) < 30);
        row = ($urandom_range(0, 9) == 0) ? ONES_W'(MAX_CELLS_DEF)
                                          : ONES_W'($urandom_range(0, 5));
        col = ($urandom_range(0, 9) == 0) ? ONES_W'(MAX_CELLS_DEF)
                                          : ONES_W'($urandom_range(0, 5));
        limit = 2 * int'(model_half);
        if (limit > 64)
            limit = 64;
        if (limit == 0)
            limit = 4;
        if ($urandom_range(0, 9) == 0)
            span = limit;
        else
            span = $urandom_range(1, (limit < 12) ? limit : 12);
        if ($urandom_range(0, 9) == 0)
            span = (span + 4 > 64) ? 64 : span + 4;
        for (int p = 0; p < span; p++)
        begin
            cb = ($urandom_range(0, 19) == 0) ? CELL_W'($urandom_range(2, 3))
                                              : CELL_W'($urandom_range(0, 1));
            ca = ($urandom_range(0, 19) == 0) ? CELL_W'($urandom_range(2, 3))
                                              : CELL_W'($urandom_range(0, 1));
            record_cell(row, col, cb, ca, POS_W'(p));
        end
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 3) == 0)
                read_counter(ONES_W'($urandom_range(0, 5)), ONES_W'($urandom_range(0, 5)),
                             SEL_W'($urandom_range(0, BIN_COUNT - 1)));
            else
                read_counter(row, col, SEL_W'($urandom_range(0, BIN_COUNT - 1)));
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [HALF_W-1:0] half;
        int                target;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       half = HALF_W'($urandom_range(2, 31));
                1:       half = HALF_RESET;
                2:       half = 1;
                3:       half = '1;
                4:       half = 0;
                default: half = HALF_W'($urandom_range(0, 63));
            endcase
            set_half_length(half);
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_config_pair();
                else
                    issue_beat(1'($urandom), ONES_W'($urandom), ONES_W'($urandom),
                               CELL_W'($urandom), CELL_W'($urandom),
                               POS_W'($urandom), SEL_W'($urandom));
            end
        end
    endtask

    always @(posedge clk)
    begin : check_counts
        logic [OUT_W-1:0] want;
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
            begin
                note_mismatch("unexpected beat,", '0, count_value);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (count_value !== want)
                    note_mismatch("read beat", want, count_value);
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_cleared_store();
        test_groups_and_pairs();
        test_ignored_cells();
        test_outside_table();
        test_half_extremes();
        test_random_traffic();
        start <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS binary_transition_histogram");
        else
            $display("FAIL binary_transition_histogram");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL binary_transition_histogram");
        $finish;
    end

endmodule
